// ===== rtl/rbh_pkg.sv =====
// ----------------------------------------------------------------------------
// rbh_pkg
// Shared types and constants of the range-binned histogram core.
// ----------------------------------------------------------------------------
package rbh_pkg;

	// default number of bins held in the count store
	localparam int BINS_DEF = 256;

	// APB register map: three 32-bit registers at byte offsets 0, 4, 8
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic signed [31:0] RANGE_LOW_RST  = 32'sd0;
	localparam logic signed [31:0] RANGE_HIGH_RST = 32'sd65536;
	localparam logic [8:0]         BIN_COUNT_RST  = 9'd256;

	typedef enum logic [1:0] {
		FUNC_ADD   = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		REG_RANGE_LOW  = 2'd0,
		REG_RANGE_HIGH = 2'd1,
		REG_BIN_COUNT  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
		logic [8:0]         bin_count;
	} cfg_t;

endpackage

// ===== rtl/rbh_req_if.sv =====
// ----------------------------------------------------------------------------
// rbh_req_if
// Request channel of the histogram core: add, read or clear beats.
// ----------------------------------------------------------------------------
interface rbh_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [31:0] sample;
	logic               sample_is_nan;
	logic [7:0]         bin_index;

	modport source (output valid, output func, output sample, output sample_is_nan,
		output bin_index, input ready);
	modport sink (input valid, input func, input sample, input sample_is_nan,
		input bin_index, output ready);
endinterface

// ===== rtl/rbh_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rbh_rsp_if
// Response channel of the histogram core: one beat per read request.
// ----------------------------------------------------------------------------
interface rbh_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] bin_total;
	logic        index_error;

	modport source (output valid, output bin_total, output index_error, input ready);
	modport sink (input valid, input bin_total, input index_error, output ready);
endinterface

// ===== rtl/range_binned_histogram_core.sv =====
// ----------------------------------------------------------------------------
// range_binned_histogram_core
// Uniform-bin histogram of Q16.16 samples with saturating 32-bit counts.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per beat: func 0 adds a sample, func 1 reads a
//   bin, func 2 clears every bin, func 3 is dropped. Only a read returns a
//   beat on rsp (bin_total, index_error). Bounds and bin count are set over
//   APB and may be written only while the core is idle.
//   Requests are taken one at a time; req.ready is high only when idle.
//   Add: from accept to the next accept the core runs ST_CHECK, ST_MUL,
//   ST_DIV (the radix-2 divider, one bin-index bit per cycle over IW =
//   clog2(BINS) bits), then a read-modify-write of the count RAM.
//   A sample on the high bound skips the divider; a NaN or out-of-range
//   sample is dropped after the range check.
//   Read: the count store is read on acceptance; ST_RESP then loads the
//   output register once it is free. Clear: one RAM entry written per cycle.
//   After reset the same clearing pass runs before req.ready first rises;
//   APB writes are taken throughout. rsp is held in an output register;
//   a stalled receiver holds the next read in ST_RESP, and every request
//   behind it; add and clear requests before it go on underneath.
// ----------------------------------------------------------------------------
module range_binned_histogram_core #(
	parameter int BINS = rbh_pkg::BINS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	rbh_req_if.sink                    req,
	rbh_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rbh_pkg::ADDR_W-1:0] paddr,
	input  logic [rbh_pkg::DATA_W-1:0] pwdata,
	output logic [rbh_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import rbh_pkg::*;

	localparam int IW   = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int CW   = $clog2(BINS + 1);
	localparam int NW   = (CW > 9) ? CW : 9;
	localparam int NUMW = 32 + CW;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_RD,
		ST_UPD,
		ST_RESP
	} state_t;

	cfg_t cfg;

	state_t             state_q;
	logic [IW-1:0]      clr_addr_q;
	logic [IW-1:0]      addr_q;
	logic signed [31:0] sample_q;
	logic               nan_q;
	logic               err_q;
	logic [31:0]        diff_q;
	logic [31:0]        den_q;
	logic [NUMW-1:0]    num_q;
	logic               div_start_q;
	logic               out_valid_q;
	logic [31:0]        bin_total_q;
	logic               index_error_q;

	logic [NW-1:0] bc_ext;
	logic [NW-1:0] nb_ext;
	logic [CW-1:0] nb;
	logic          idx_ok;
	logic          accept;
	logic          out_free;
	logic          div_done;
	logic [IW-1:0] div_quo;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic          ram_re;
	logic [IW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	logic signed [32:0] x_ext;
	logic signed [32:0] lo_ext;
	logic signed [32:0] hi_ext;

	rbh_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// bins in use: bin_count clamped to 1..BINS
	always_comb begin
		bc_ext = NW'(cfg.bin_count);
		if (bc_ext == '0)
			nb_ext = NW'(1);
		else if (bc_ext > NW'(BINS))
			nb_ext = NW'(BINS);
		else
			nb_ext = bc_ext;
		nb = CW'(nb_ext);
	end

	assign idx_ok   = (NW'(req.bin_index) < nb_ext);
	assign accept   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	assign x_ext  = {sample_q[31], sample_q};
	assign lo_ext = {cfg.range_low[31], cfg.range_low};
	assign hi_ext = {cfg.range_high[31], cfg.range_high};

	rbh_div #(
		.NW (NUMW),
		.QW (IW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// count store ports
	always_comb begin
		ram_we    = (state_q == ST_CLEAR) || (state_q == ST_UPD);
		ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : addr_q;
		if (state_q == ST_CLEAR)
			ram_wdata = '0;
		else if (&ram_rdata)
			ram_wdata = ram_rdata;
		else
			ram_wdata = ram_rdata + 32'd1;
		ram_re    = (state_q == ST_RD) ||
			(accept && req.func == FUNC_READ && idx_ok);
		ram_raddr = (state_q == ST_RD) ? addr_q : IW'(req.bin_index);
	end

	rbh_ram #(
		.WIDTH (32),
		.DEPTH (BINS),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			addr_q        <= '0;
			sample_q      <= '0;
			nan_q         <= 1'b0;
			err_q         <= 1'b0;
			diff_q        <= '0;
			den_q         <= '0;
			num_q         <= '0;
			div_start_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			bin_total_q   <= '0;
			index_error_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			// ST_RESP reloads the output register itself
			if (out_valid_q && rsp.ready && state_q != ST_RESP)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + IW'(1);
					if (clr_addr_q == IW'(BINS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						sample_q <= req.sample;
						nan_q    <= req.sample_is_nan;
						case (req.func)
							FUNC_ADD:   state_q <= ST_CHECK;
							FUNC_READ: begin
								err_q   <= !idx_ok;
								state_q <= ST_RESP;
							end
							FUNC_CLEAR: begin
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CHECK: begin
					if (nan_q || x_ext < lo_ext || x_ext > hi_ext) begin
						state_q <= ST_IDLE;
					end else if (x_ext == hi_ext) begin
						// upper bound lands in the last bin, no divide
						addr_q  <= IW'(nb - CW'(1));
						state_q <= ST_RD;
					end else begin
						diff_q  <= 32'(x_ext - lo_ext);
						den_q   <= 32'(hi_ext - lo_ext);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					num_q       <= NUMW'(diff_q) * NUMW'(nb);
					div_start_q <= 1'b1;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						addr_q  <= div_quo;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
				end
				ST_RESP: begin
					// read data holds in the RAM output register until taken
					if (out_free) begin
						out_valid_q   <= 1'b1;
						bin_total_q   <= err_q ? 32'd0 : ram_rdata;
						index_error_q <= err_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.bin_total   = bin_total_q;
	assign rsp.index_error = index_error_q;

endmodule

// ===== rtl/rbh_ram.sv =====
// ----------------------------------------------------------------------------
// rbh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rbh_regs.sv =====
// ----------------------------------------------------------------------------
// rbh_regs
// APB configuration registers: range_low, range_high, bin_count.
// ----------------------------------------------------------------------------
module rbh_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rbh_pkg::ADDR_W-1:0] paddr,
	input  logic [rbh_pkg::DATA_W-1:0] pwdata,
	output logic [rbh_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output rbh_pkg::cfg_t              cfg
);
	import rbh_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	// byte offset 4*i, low two address bits ignored
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low  <= RANGE_LOW_RST;
			cfg_q.range_high <= RANGE_HIGH_RST;
			cfg_q.bin_count  <= BIN_COUNT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RANGE_LOW:  cfg_q.range_low  <= pwdata;
				REG_RANGE_HIGH: cfg_q.range_high <= pwdata;
				REG_BIN_COUNT:  cfg_q.bin_count  <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RANGE_LOW:  prdata = cfg_q.range_low;
			REG_RANGE_HIGH: prdata = cfg_q.range_high;
			REG_BIN_COUNT:  prdata = DATA_W'(cfg_q.bin_count);
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/rbh_div.sv =====
// ----------------------------------------------------------------------------
// rbh_div
// Restoring radix-2 divider, one quotient bit per cycle, MSB first.
// The quotient is known to fit in QW bits (num < den << QW).
// ----------------------------------------------------------------------------
module rbh_div #(
	parameter int NW = 41,
	parameter int QW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [31:0]   den,
	output logic          done,
	output logic [QW-1:0] quo
);

	localparam int CNTW = $clog2(QW + 1);

	logic [NW-1:0]   rem_q;
	logic [NW-1:0]   den_sh_q;
	logic [QW-1:0]   quo_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic            fits;

	assign fits = (rem_q >= den_sh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			den_sh_q <= '0;
			quo_q    <= '0;
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q    <= num;
				den_sh_q <= NW'(den) << (QW - 1);
				quo_q    <= '0;
				cnt_q    <= CNTW'(QW);
				busy_q   <= 1'b1;
			end else if (busy_q) begin
				if (fits)
					rem_q <= rem_q - den_sh_q;
				quo_q    <= (quo_q << 1) | QW'(fits);
				den_sh_q <= den_sh_q >> 1;
				cnt_q    <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/rbh_checker.sv =====
// ----------------------------------------------------------------------------
// rbh_checker
// Port-level checks of the histogram core, bound to the top level.
// ----------------------------------------------------------------------------
module rbh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_func,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] bin_total,
	input logic        index_error,
	input logic        pready
);
	import rbh_pkg::*;

	// response beat holds while the receiver stalls
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(bin_total) &&
		$stable(index_error))
		else $error("rsp beat changed while stalled");

	// an out-of-range read never reports a count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && index_error |-> bin_total == 32'd0)
		else $error("index_error with nonzero bin_total");

	// one request at a time: ready drops after every add, read or clear beat
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready &&
		(req_func == FUNC_ADD || req_func == FUNC_READ || req_func == FUNC_CLEAR)
		|=> !req_ready)
		else $error("request accepted while busy");

	// a new response cannot appear in the cycle right after an accept
	a_rsp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("response earlier than the count store allows");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind range_binned_histogram_core rbh_checker u_rbh_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_func    (req.func),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.bin_total   (rsp.bin_total),
	.index_error (rsp.index_error),
	.pready      (pready)
);

// ===== tb/range_binned_histogram_core_test.sv =====
// ----------------------------------------------------------------------------
// range_binned_histogram_core_test
// Self-checking bench for the uniform-bin histogram core: a shadow histogram
// predicts every read beat, while add, read, clear and unused requests are
// streamed under random sender gaps and receiver stalls across many range and
// bin-count settings written over APB.
// ----------------------------------------------------------------------------
module range_binned_histogram_core_test;
	import rbh_pkg::*;

	localparam logic [1:0] FUNC_NOP = 2'd3;  // unused code, must be dropped
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = BINS_DEF + 40;  // covers a full clearing pass

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] sample;
		logic        sample_is_nan;
		logic [7:0]  bin_index;
	} hist_req_t;

	typedef struct packed {
		logic [31:0] total;
		logic        idx_err;
	} bin_readout_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	rbh_req_if hist_req();
	rbh_rsp_if hist_rsp();

	range_binned_histogram_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (hist_req),
		.rsp     (hist_rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the count store and of the registers
	logic [31:0]        bin_tally [BINS_DEF];
	logic signed [31:0] lo_bound = RANGE_LOW_RST;
	logic signed [31:0] hi_bound = RANGE_HIGH_RST;
	logic [8:0]         bins_reg = BIN_COUNT_RST;

	hist_req_t    pending [$];
	bin_readout_t readouts_due [$];

	logic req_taken = 1'b0;
	int   gap_left = 0;
	int   stall_left = 0;
	int   req_gap_odds = 0;
	int   rsp_stall_odds = 0;
	int   cycle_count = 0;
	int   fails = 0;
	int   n_binned = 0;
	int   n_skipped = 0;
	int   n_reads = 0;
	int   n_clears = 0;
	int   n_ignored = 0;
	int   n_settings = 1;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int bins_in_use();
		if (bins_reg == 0)
			return 1;
		if (bins_reg > BINS_DEF)
			return BINS_DEF;
		return int'(bins_reg);
	endfunction

	// shadow histogram: applies one accepted request, queues a readout for reads
	function automatic void histogram_apply(input logic [1:0] func,
		input logic signed [31:0] x, input logic nan, input logic [7:0] idx);
		longint xv, lo, hi;
		longint unsigned num, den, q;
		int nb;
		bin_readout_t r;
		nb = bins_in_use();
		xv = longint'(x);
		lo = longint'(lo_bound);
		hi = longint'(hi_bound);
		case (func)
			FUNC_ADD: begin
				if (nan || xv < lo || xv > hi) begin
					n_skipped++;
				end else begin
					if (xv == hi) begin
						q = 64'(nb - 1);
					end else begin
						num = longint'(xv - lo) * longint'(nb);
						den = hi - lo;
						q = num / den;
						if (q >= nb)
							q = 64'(nb - 1);
					end
					if (bin_tally[q] != 32'hFFFF_FFFF)
						bin_tally[q]++;
					n_binned++;
				end
			end
			FUNC_READ: begin
				if (idx < nb) begin
					r.total = bin_tally[idx];
					r.idx_err = 1'b0;
				end else begin
					r.total = '0;
					r.idx_err = 1'b1;
				end
				readouts_due.push_back(r);
				n_reads++;
			end
			FUNC_CLEAR: begin
				foreach (bin_tally[i])
					bin_tally[i] = '0;
				n_clears++;
			end
			default: n_ignored++;
		endcase
	endfunction

	function automatic void queue_req(input logic [1:0] f, input logic [31:0] s,
		input logic n, input logic [7:0] i);
		hist_req_t item;
		item.func = f;
		item.sample = s;
		item.sample_is_nan = n;
		item.bin_index = i;
		pending.push_back(item);
	endfunction

	// samples aimed at the bounds, just past them, near bin edges, or anywhere
	function automatic logic [31:0] pick_sample();
		longint lo, hi, span, v;
		int nb;
		lo = longint'(lo_bound);
		hi = longint'(hi_bound);
		nb = bins_in_use();
		span = hi - lo;
		case ($urandom_range(0, 9))
			0: v = lo;
			1: v = hi;
			2: v = lo - 1;
			3: v = hi + longint'($urandom_range(1, 3));
			4, 5: v = lo + (span * longint'($urandom_range(0, nb))) / nb
				+ longint'($urandom_range(0, 2)) - 1;
			6: v = longint'($signed($urandom));
			default: begin
				if (span < 0)
					v = longint'($signed($urandom));
				else
					v = lo + longint'({$urandom, $urandom} % $unsigned(span + 1));
			end
		endcase
		return v[31:0];
	endfunction

	task automatic fill_random(input int n);
		int roll;
		int nb;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(0, 99);
			nb = bins_in_use();
			if (roll < 58)
				queue_req(FUNC_ADD, pick_sample(), $urandom_range(0, 15) == 0,
					8'($urandom));
			else if (roll < 94)
				queue_req(FUNC_READ, $urandom, 1'($urandom_range(0, 1)),
					8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, nb - 1)
						: $urandom_range(0, 255)));
			else if (roll < 96)
				queue_req(FUNC_CLEAR, $urandom, 1'($urandom_range(0, 1)), 8'($urandom));
			else
				queue_req(FUNC_NOP, $urandom, 1'($urandom_range(0, 1)), 8'($urandom));
		end
	endtask

	task automatic cfg_write(input reg_idx_t which, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (which)
			REG_RANGE_LOW:  lo_bound = value;
			REG_RANGE_HIGH: hi_bound = value;
			REG_BIN_COUNT:  bins_reg = value[8:0];
			default: ;
		endcase
	endtask

	task automatic set_range(input logic [31:0] lo, input logic [31:0] hi,
		input logic [8:0] nbins);
		cfg_write(REG_RANGE_LOW, lo);
		cfg_write(REG_RANGE_HIGH, hi);
		cfg_write(REG_BIN_COUNT, {23'd0, nbins});
		n_settings++;
	endtask

	task automatic random_settings();
		logic [31:0] a, b, t;
		logic [8:0] nbins;
		case ($urandom_range(0, 7))
			0: nbins = 9'd1;
			1: nbins = 9'd256;
			2: nbins = 9'd0;
			3: nbins = 9'($urandom_range(257, 511));
			4: nbins = 9'd2;
			default: nbins = 9'($urandom_range(1, 256));
		endcase
		case ($urandom_range(0, 7))
			0: begin
				a = 32'h8000_0000;
				b = 32'h7FFF_FFFF;
			end
			1: begin
				// a span of 1 to 600 may be narrower than the bin count and leave some bins unreachable
				a = $urandom_range(0, 2000000) - 1000000;
				b = a + $urandom_range(1, 600);
			end
			2: begin
				a = $urandom;
				b = a;
			end
			3: begin
				a = 1000 + $urandom_range(0, 100000);
				b = -a;
			end
			default: begin
				a = $urandom;
				b = $urandom;
				if ($signed(a) > $signed(b)) begin
					t = a;
					a = b;
					b = t;
				end
			end
		endcase
		set_range(a, b, nbins);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending.size() != 0 || hist_req.valid || readouts_due.size() != 0);
	endtask

	// adds and clears give no beat, so let any of them finish before touching registers
	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// request driver
	always @(negedge clk) begin
		hist_req_t nxt;
		if (arst_n && (!hist_req.valid || req_taken)) begin
			if (gap_left == 0 && req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1)
				gap_left = $urandom_range(1, 9);
			if (gap_left != 0) begin
				gap_left--;
				hist_req.valid <= 1'b0;
			end else if (pending.size() != 0) begin
				nxt = pending.pop_front();
				hist_req.valid <= 1'b1;
				hist_req.func <= nxt.func;
				hist_req.sample <= nxt.sample;
				hist_req.sample_is_nan <= nxt.sample_is_nan;
				hist_req.bin_index <= nxt.bin_index;
			end else begin
				hist_req.valid <= 1'b0;
			end
		end
	end

	// response back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left == 0 && rsp_stall_odds != 0 && $urandom_range(1, rsp_stall_odds) == 1)
				stall_left = $urandom_range(1, 9);
			if (stall_left != 0) begin
				stall_left--;
				hist_rsp.ready <= 1'b0;
			end else begin
				hist_rsp.ready <= 1'b1;
			end
		end
	end

	// monitor: predict on accepted requests, check each response beat
	always @(posedge clk) begin
		bin_readout_t want;
		req_taken <= arst_n && hist_req.valid && hist_req.ready;
		if (arst_n && hist_req.valid && hist_req.ready)
			histogram_apply(hist_req.func, hist_req.sample, hist_req.sample_is_nan,
				hist_req.bin_index);
		if (arst_n && hist_rsp.valid && hist_rsp.ready) begin
			if (readouts_due.size() == 0) begin
				$error("unexpected beat: bin_total=%0d index_error=%0b",
					hist_rsp.bin_total, hist_rsp.index_error);
				fails++;
			end else begin
				want = readouts_due.pop_front();
				if (hist_rsp.bin_total !== want.total) begin
					$error("bin_total: expected %0d, got %0d", want.total, hist_rsp.bin_total);
					fails++;
				end
				if (hist_rsp.index_error !== want.idx_err) begin
					$error("index_error: expected %0b, got %0b", want.idx_err,
						hist_rsp.index_error);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		foreach (bin_tally[i])
			bin_tally[i] = '0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hist_req.valid = 1'b0;
		hist_req.func = FUNC_ADD;
		hist_req.sample = '0;
		hist_req.sample_is_nan = 1'b0;
		hist_req.bin_index = '0;
		hist_rsp.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: [0, 1.0] over 256 bins
		req_gap_odds = 4;
		rsp_stall_odds = 3;
		queue_req(FUNC_READ, 32'h0, 1'b0, 8'd0);
		queue_req(FUNC_ADD, 32'h0, 1'b0, 8'd0);
		queue_req(FUNC_ADD, 32'h0001_0000, 1'b0, 8'd0);   // on the high bound
		queue_req(FUNC_ADD, 32'h0000_8000, 1'b0, 8'd0);
		queue_req(FUNC_ADD, 32'hFFFF_FFFF, 1'b0, 8'd0);   // just below the range
		queue_req(FUNC_ADD, 32'h0001_0001, 1'b0, 8'd0);   // just above
		queue_req(FUNC_ADD, 32'h0000_0064, 1'b1, 8'd0);   // NaN inside the range
		queue_req(FUNC_ADD, 32'h7FFF_FFFF, 1'b0, 8'd0);
		queue_req(FUNC_ADD, 32'h8000_0000, 1'b0, 8'd0);
		queue_req(FUNC_READ, 32'hFFFF_FFFF, 1'b1, 8'd0);
		queue_req(FUNC_READ, 32'h0, 1'b0, 8'd128);
		queue_req(FUNC_READ, 32'h0, 1'b0, 8'd255);
		queue_req(FUNC_NOP, 32'h0000_0005, 1'b0, 8'd0);
		queue_req(FUNC_CLEAR, 32'h0, 1'b0, 8'd0);
		queue_req(FUNC_READ, 32'h0, 1'b0, 8'd255);
		settle();

		// full signed range, a single bin
		set_range(32'h8000_0000, 32'h7FFF_FFFF, 9'd1);
		queue_req(FUNC_ADD, 32'h8000_0000, 1'b0, 8'd0);
		queue_req(FUNC_ADD, 32'h7FFF_FFFF, 1'b0, 8'd0);
		queue_req(FUNC_READ, 32'h0, 1'b0, 8'd0);
		queue_req(FUNC_READ, 32'h0, 1'b0, 8'd1);
		settle();

		// zero-width range, bin count of zero
		set_range(32'd5, 32'd5, 9'd0);
		queue_req(FUNC_ADD, 32'd5, 1'b0, 8'd0);
		queue_req(FUNC_ADD, 32'd4, 1'b0, 8'd0);
		queue_req(FUNC_READ, 32'h0, 1'b0, 8'd0);
		settle();

		// inverted range, bin count above the store size
		set_range(32'd100, -32'sd100, 9'd511);
		queue_req(FUNC_ADD, 32'd0, 1'b0, 8'd0);
		queue_req(FUNC_READ, 32'h0, 1'b0, 8'd255);

		for (int p = 0; p < 7; p++) begin
			settle();
			random_settings();
			if (p == 6) begin
				req_gap_odds = 0;
				rsp_stall_odds = 0;
			end else begin
				req_gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
				rsp_stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
			end
			fill_random(73);
			wait_drained();  // sender holds off until every read beat is back
			fill_random(73);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d requests over %0d range/bin settings: %0d samples binned,",
			n_binned + n_skipped + n_reads + n_clears + n_ignored, n_settings, n_binned);
		$display("  %0d samples skipped, %0d reads checked, %0d clears, %0d unused codes.",
			n_skipped, n_reads, n_clears, n_ignored);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
